FILE: hw/rtl/tndc_pkg.sv
// shared types and constants for the top-n distinct value counter
`default_nettype none

package tndc_pkg;

  localparam int VALUE_W = 32;
  localparam int COUNT_W = 32;
  localparam int KEEP_W  = 5;

  localparam logic [KEEP_W-1:0]  KEEP_RESET = 5'd5;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
  localparam logic [COUNT_W-1:0] COUNT_ONE  = 32'd1;

  // request codes carried in req_type
  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_READ   = 2'd1,
    REQ_CLEAR  = 2'd2
  } req_code_t;

  // one table entry as held in a cell
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] count;
    logic               valid;
  } entry_t;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic               insert_new;
    logic               insert_hit;
    logic               clear;
    logic               trim;
    logic [VALUE_W-1:0] value;
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/tndc_req_if.sv
// request channel: valid/ready with request code and sample value
`default_nettype none

interface tndc_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic signed [31:0] value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink (input valid, input req_type, input value, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/tndc_res_if.sv
// result channel: valid/ready with one table entry per word
`default_nettype none

interface tndc_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] entry_value;
  logic [31:0]        entry_count;
  logic               last;

  modport source (output valid, output entry_value, output entry_count, output last,
                  input ready);
  modport sink (input valid, input entry_value, input entry_count, input last,
                output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/tndc_cell.sv
// one slot of the sorted table: compare, shift-in from neighbor, count update
`default_nettype none

module tndc_cell
  import tndc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cell_ctrl_t ctrl,
  input  wire logic       active,
  input  wire logic       take_above,
  input  wire entry_t     prev,
  output logic            take,
  output logic            hit,
  output entry_t          cur
);

  entry_t held;

  // new value belongs here or above when this slot is empty or smaller
  assign take = !held.valid || ($signed(ctrl.value) > $signed(held.value));
  assign hit  = held.valid && (ctrl.value == held.value);
  assign cur  = held;

  // slot update: trim, clear, shift down on insert, or count bump
  always_ff @(posedge clk) begin
    if (rst) begin
      held.valid <= 1'b0;
    end else if (ctrl.trim) begin
      held.valid <= held.valid && active;
    end else if (ctrl.clear) begin
      held.valid <= 1'b0;
    end else if (ctrl.insert_new) begin
      if (take_above) begin
        held.value <= prev.value;
        held.count <= prev.count;
        held.valid <= prev.valid && active;
      end else if (take) begin
        held.value <= ctrl.value;
        held.count <= COUNT_ONE;
        held.valid <= active;
      end
    end else if (ctrl.insert_hit && hit && (held.count != COUNT_MAX)) begin
      held.count <= held.count + COUNT_ONE;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/tndc_readout.sv
// read-out sequencer: walks the table smallest first and registers each word
`default_nettype none

module tndc_readout
  import tndc_pkg::*;
#(
  parameter int MAX_ENTRIES = 16,
  localparam int CW = $clog2(MAX_ENTRIES + 1),
  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [CW-1:0] keff,
  input  wire logic [CW-1:0] fill,
  input  wire entry_t        entries [MAX_ENTRIES],
  output logic               busy,
  tndc_res_if.source         res
);

  typedef enum logic {
    IDLE,
    SEND
  } state_t;

  state_t        state;
  logic [CW-1:0] pos;
  logic [CW-1:0] sel;
  logic [CW-1:0] idx;
  logic          sel_last;
  entry_t        pick;

  assign busy = (state != IDLE);

  // held entries sit largest first in the chain, so word j comes from slot fill-1-j
  always_comb begin
    sel      = (state == IDLE) ? '0 : pos + CW'(1);
    idx      = fill - CW'(1) - sel;
    sel_last = (sel == keff - CW'(1));
    if (sel < fill) begin
      pick = entries[idx[IW-1:0]];
    end else begin
      pick = '0;
    end
  end

  // state and output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      res.valid <= 1'b0;
      pos       <= '0;
    end else begin
      unique case (state)
        IDLE: begin
          if (start) begin
            state           <= SEND;
            pos             <= '0;
            res.valid       <= 1'b1;
            res.entry_value <= pick.value;
            res.entry_count <= pick.count;
            res.last        <= sel_last;
          end
        end
        SEND: begin
          if (res.ready) begin
            if (res.last) begin
              state     <= IDLE;
              res.valid <= 1'b0;
            end else begin
              pos             <= sel;
              res.entry_value <= pick.value;
              res.entry_count <= pick.count;
              res.last        <= sel_last;
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/top_n_distinct_value_counter_core.sv
// Top-n distinct value counter: keeps the largest distinct values with counts.
// Channels: req (sink) takes a request code and a signed 32-bit value; res
// (source) gives entry_value, entry_count and last. keep_count is written on
// cfg_we with cfg_wdata; 0 acts as 1 and values above MAX_ENTRIES act as
// MAX_ENTRIES.
// The table is a chain of MAX_ENTRIES cells kept sorted largest first. An
// insert or clear updates every cell at the edge that takes it, so a run of
// inserts goes at one word per cycle while req.ready is high.
// A read registers the first word at the edge that takes it, then gives the
// clamped keep_count of words, smallest value first, one per cycle while
// res.ready is high; req.ready stays low until the last word is taken.
// A stalled res simply holds its word. A keep_count write drops the smallest
// entries on the next cycle, with req.ready low during that cycle.
// Reset (rst, synchronous) empties the table and sets keep_count to 5.
`default_nettype none

module top_n_distinct_value_counter_core
  import tndc_pkg::*;
#(
  parameter int MAX_ENTRIES = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [KEEP_W-1:0] cfg_wdata,
  tndc_req_if.sink               req,
  tndc_res_if.source             res
);

  localparam int CW = $clog2(MAX_ENTRIES + 1);

  logic [KEEP_W-1:0]    keep_count;
  logic                 trim_pend;
  logic [CW-1:0]        fill;
  logic [CW-1:0]        keff;
  logic                 fire;
  logic                 busy;
  logic                 hit_any;
  logic                 ins_ok;
  cell_ctrl_t           ctrl;
  logic [MAX_ENTRIES-1:0] active;
  logic [MAX_ENTRIES-1:0] take;
  logic [MAX_ENTRIES-1:0] hit;
  logic [MAX_ENTRIES-1:0] ins;
  entry_t               entries [MAX_ENTRIES];

  // effective keep count, clamped to the table size
  always_comb begin
    if (keep_count == '0) begin
      keff = CW'(1);
    end else if (32'(keep_count) > 32'(MAX_ENTRIES)) begin
      keff = CW'(MAX_ENTRIES);
    end else begin
      keff = CW'(keep_count);
    end
  end

  assign req.ready = !busy && !trim_pend;
  assign fire      = req.valid && req.ready;
  assign hit_any   = |hit;
  assign ins_ok    = |(ins & active);

  // command broadcast to the cells
  always_comb begin
    ctrl.value      = req.value;
    ctrl.trim       = trim_pend;
    ctrl.clear      = fire && (req.req_type == REQ_CLEAR);
    ctrl.insert_new = fire && (req.req_type == REQ_INSERT) && !hit_any;
    ctrl.insert_hit = fire && (req.req_type == REQ_INSERT) && hit_any;
  end

  // chain of slots, each taking its upper neighbor on a shift
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic   above;
    entry_t up;

    assign active[i] = (CW'(i) < keff);
    assign ins[i]    = take[i] && !above;

    if (i == 0) begin : g_head
      assign above = 1'b0;
      assign up    = '0;
    end else begin : g_body
      assign above = take[i-1];
      assign up    = entries[i-1];
    end

    tndc_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .active     (active[i]),
      .take_above (above),
      .prev       (up),
      .take       (take[i]),
      .hit        (hit[i]),
      .cur        (entries[i])
    );
  end

  // keep count register and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      keep_count <= KEEP_RESET;
      trim_pend  <= 1'b0;
      fill       <= '0;
    end else begin
      trim_pend <= cfg_we;
      if (cfg_we) begin
        keep_count <= cfg_wdata;
      end
      if (trim_pend) begin
        if (fill > keff) begin
          fill <= keff;
        end
      end else if (ctrl.clear) begin
        fill <= '0;
      end else if (ctrl.insert_new && ins_ok && (fill < keff)) begin
        fill <= fill + CW'(1);
      end
    end
  end

  tndc_readout #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_readout (
    .clk     (clk),
    .rst     (rst),
    .start   (fire && (req.req_type == REQ_READ)),
    .keff    (keff),
    .fill    (fill),
    .entries (entries),
    .busy    (busy),
    .res     (res)
  );

  // valid bits as a vector, and strict descending order of held values
  logic [MAX_ENTRIES-1:0] valid_vec;
  logic                   order_ok;

  always_comb begin
    order_ok = 1'b1;
    for (int j = 0; j < MAX_ENTRIES; j++) begin
      valid_vec[j] = entries[j].valid;
    end
    for (int j = 1; j < MAX_ENTRIES; j++) begin
      if (entries[j].valid &&
          !($signed(entries[j-1].value) > $signed(entries[j].value))) begin
        order_ok = 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_fill_matches_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == 32'(fill))
    else $error("fill level differs from number of held slots");

  a_valid_packed: assert property (@(posedge clk) disable iff (rst)
    (fill == '0) || valid_vec[0])
    else $error("held slots not packed at head of chain");

  a_fill_within_keep: assert property (@(posedge clk) disable iff (rst)
    !trim_pend |-> (fill <= keff))
    else $error("table holds more entries than keep count");

  a_sorted: assert property (@(posedge clk) disable iff (rst)
    order_ok)
    else $error("held values not in strict descending order");

  a_no_accept_in_readout: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> !req.ready)
    else $error("request accepted during read-out");
`endif

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// testbench for the top-n distinct value counter core: directed and random requests
module tb_top;
  import tndc_pkg::*;

  localparam int SLOTS = 16;
  localparam int LONG_HOLD = 200;
  localparam int RANDOM_ITEMS = 360;
  localparam int CALM_ITEMS = 60;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // one word of a table read-out
  typedef struct {
    logic signed [VALUE_W-1:0] value;
    logic [COUNT_W-1:0]        count;
    logic                      last;
  } readout_word_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [KEEP_W-1:0] cfg_wdata;

  tndc_req_if req_ch ();
  tndc_res_if res_ch ();

  top_n_distinct_value_counter_core #(
    .MAX_ENTRIES(SLOTS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .req      (req_ch),
    .res      (res_ch)
  );

  // mirror of the table held in the block
  logic signed [VALUE_W-1:0] kept_val [SLOTS];
  logic [COUNT_W-1:0]        kept_cnt [SLOTS];
  logic                      kept_ok  [SLOTS];
  logic [KEEP_W-1:0]         keep_reg;

  readout_word_t pending_words[$];
  int  fail_count = 0;
  bit  calm = 0;
  bit  hold_res_req = 0;

  // effective keep count: 0 acts as 1, above the slot count acts as the slot count
  function automatic int keep_limit();
    int k;
    k = int'(keep_reg);
    if (k < 1) k = 1;
    if (k > SLOTS) k = SLOTS;
    return k;
  endfunction

  function automatic int used_slots();
    int n;
    n = 0;
    for (int i = 0; i < SLOTS; i++) if (kept_ok[i]) n = n + 1;
    return n;
  endfunction

  function automatic int smallest_slot();
    int best;
    best = SLOTS;
    for (int i = 0; i < SLOTS; i++) begin
      if (kept_ok[i] && (best == SLOTS || kept_val[i] < kept_val[best])) best = i;
    end
    return best;
  endfunction

  // a lowered keep count evicts the smallest entries
  function automatic void drop_to_limit();
    while (used_slots() > keep_limit()) kept_ok[smallest_slot()] = 1'b0;
  endfunction

  function automatic void tally_insert(logic signed [VALUE_W-1:0] v);
    int dest;
    int m;
    for (int i = 0; i < SLOTS; i++) begin
      if (kept_ok[i] && kept_val[i] == v) begin
        if (kept_cnt[i] != COUNT_MAX) kept_cnt[i] = kept_cnt[i] + COUNT_ONE;
        return;
      end
    end
    dest = SLOTS;
    if (used_slots() >= keep_limit()) begin
      // full: drop values under the smallest, else replace the smallest
      m = smallest_slot();
      if (v < kept_val[m]) return;
      dest = m;
    end else begin
      for (int i = 0; i < SLOTS; i++) if (!kept_ok[i] && dest == SLOTS) dest = i;
    end
    kept_val[dest] = v;
    kept_cnt[dest] = COUNT_ONE;
    kept_ok[dest]  = 1'b1;
  endfunction

  // held entries ascending, then empty slots, effective keep-count words in all
  function automatic void queue_readout();
    int idx [SLOTS];
    int n;
    int k;
    int t;
    int b;
    readout_word_t w;
    n = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (kept_ok[i]) begin
        idx[n] = i;
        n = n + 1;
      end
    end
    for (int a = 1; a < n; a++) begin
      t = idx[a];
      b = a;
      while (b > 0 && kept_val[idx[b-1]] > kept_val[t]) begin
        idx[b] = idx[b-1];
        b = b - 1;
      end
      idx[b] = t;
    end
    k = keep_limit();
    for (int r = 0; r < k; r++) begin
      w.value = (r < n) ? kept_val[idx[r]] : '0;
      w.count = (r < n) ? kept_cnt[idx[r]] : '0;
      w.last  = (r == k - 1);
      pending_words.push_back(w);
    end
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    #(8 * 400000);
    $display("top_n_distinct_value_counter_core test failed");
    $finish;
  end

  // result side: random ready bursts, one long hold-off on request
  initial begin : res_side
    int span;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_res_req) begin
        hold_res_req = 0;
        res_ch.ready <= 1'b0;
        span = LONG_HOLD;
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        res_ch.ready <= 1'b0;
        span = $urandom_range(1, 12);
      end else begin
        res_ch.ready <= 1'b1;
        span = calm ? 1 : $urandom_range(1, 24);
      end
      repeat (span) @(posedge clk);
    end
  end

  // compare each accepted word with the oldest expected one
  always @(posedge clk) begin : check_words
    readout_word_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_words.size() == 0) begin
        fail_count++;
        $display("%0t: word with none expected: value %0d count %0d last %0b",
                 $time, res_ch.entry_value, res_ch.entry_count, res_ch.last);
      end else begin
        want = pending_words.pop_front();
        if (res_ch.entry_value !== want.value) begin
          fail_count++;
          $display("%0t: entry_value expected %0d actual %0d",
                   $time, want.value, res_ch.entry_value);
        end
        if (res_ch.entry_count !== want.count) begin
          fail_count++;
          $display("%0t: entry_count expected %0d actual %0d",
                   $time, want.count, res_ch.entry_count);
        end
        if (res_ch.last !== want.last) begin
          fail_count++;
          $display("%0t: last expected %0b actual %0b", $time, want.last, res_ch.last);
        end
      end
    end
  end

  // offer one request word, with an optional random gap, and predict on acceptance
  task automatic push_item(input logic [1:0] code, input logic [VALUE_W-1:0] v);
    if (!calm && $urandom_range(0, 5) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= code;
    req_ch.value    <= v;
    do @(posedge clk); while (!req_ch.ready);
    case (code)
      REQ_INSERT: tally_insert($signed(v));
      REQ_READ:   queue_readout();
      REQ_CLEAR:  for (int i = 0; i < SLOTS; i++) kept_ok[i] = 1'b0;
      default: ;
    endcase
  endtask

  // stop offering and wait until every expected word has come
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_words.size() != 0);
    // inserts leave no word behind, so allow the last one to settle
    repeat (4) @(posedge clk);
  endtask

  task automatic write_keep(input logic [KEEP_W-1:0] k);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= k;
    @(posedge clk);
    cfg_we <= 1'b0;
    keep_reg = k;
    drop_to_limit();
  endtask

  task automatic test_empty_readout();
    push_item(REQ_READ, 32'h0);
  endtask

  // counts cannot reach saturation here: that takes 2^32-1 inserts of one value
  task automatic test_extreme_values();
    push_item(REQ_INSERT, 32'h8000_0000);
    push_item(REQ_INSERT, 32'h7fff_ffff);
    push_item(REQ_INSERT, 32'h0000_0000);
    push_item(REQ_INSERT, 32'hffff_ffff);
    push_item(REQ_INSERT, 32'h7fff_ffff);
    push_item(REQ_INSERT, 32'h8000_0000);
    push_item(REQ_READ, 32'hffff_ffff);
  endtask

  task automatic test_eviction_and_trim();
    push_item(REQ_INSERT, 32'd10);
    push_item(REQ_INSERT, 32'd20);
    push_item(REQ_INSERT, -32'sd5);
    push_item(REQ_READ, 32'h0);
    write_keep(5'd2);
    push_item(REQ_READ, 32'h0);
  endtask

  task automatic test_clear_and_unused();
    push_item(REQ_UNUSED, 32'h7fff_ffff);
    push_item(REQ_CLEAR, 32'h5555_aaaa);
    push_item(REQ_READ, 32'h0);
  endtask

  task automatic test_keep_clamping();
    write_keep(5'd0);
    push_item(REQ_INSERT, 32'd3);
    push_item(REQ_INSERT, 32'd9);
    push_item(REQ_READ, 32'h0);
    write_keep(5'd31);
    push_item(REQ_READ, 32'h0);
  endtask

  // long result hold-off stalls a read-out with requests waiting, then a pause until all words are out
  task automatic test_backpressure();
    write_keep(5'd16);
    hold_res_req = 1;
    while (hold_res_req) @(posedge clk);
    push_item(REQ_READ, 32'h0);
    for (int i = 0; i < 18; i++) push_item(REQ_INSERT, $urandom_range(0, 12));
    push_item(REQ_READ, 32'h0);
    wait_drained();
    push_item(REQ_READ, 32'h0);
  endtask

  task automatic test_random_phases();
    logic signed [VALUE_W-1:0] pool [8];
    logic [KEEP_W-1:0] k;
    logic [1:0] code;
    logic [VALUE_W-1:0] v;
    int sent;
    int phase;
    int r;
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      case (phase % 6)
        0: k = 5'd1;
        1: k = 5'd16;
        2: k = 5'd17;
        3: k = 5'd31;
        4: k = KEEP_W'($urandom_range(2, 6));
        default: k = KEEP_W'($urandom_range(0, 31));
      endcase
      write_keep(k);
      // a small pool per phase gives repeats, drops and evictions
      for (int i = 0; i < 8; i++) begin
        case ($urandom_range(0, 3))
          0: pool[i] = $urandom;
          1: pool[i] = 32'h8000_0000 + $urandom_range(0, 3);
          2: pool[i] = 32'h7fff_ffff - $urandom_range(0, 3);
          default: pool[i] = $urandom_range(0, 40) - 20;
        endcase
      end
      repeat ($urandom_range(30, 50)) begin
        r = $urandom_range(0, 99);
        if (r < 8) code = REQ_READ;
        else if (r < 11) code = REQ_CLEAR;
        else if (r < 14) code = REQ_UNUSED;
        else code = REQ_INSERT;
        v = ($urandom_range(0, 9) < 7) ? pool[$urandom_range(0, 7)] : $urandom;
        push_item(code, v);
        if (code != REQ_UNUSED) sent++;
        if (sent >= RANDOM_ITEMS - CALM_ITEMS) calm = 1;
      end
      push_item(REQ_READ, $urandom);
      sent++;
      phase++;
    end
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      kept_val[i] = '0;
      kept_cnt[i] = '0;
      kept_ok[i]  = 1'b0;
    end
    keep_reg = KEEP_RESET;
    rst             <= 1'b1;
    cfg_we          <= 1'b0;
    cfg_wdata       <= '0;
    req_ch.valid    <= 1'b0;
    req_ch.req_type <= REQ_INSERT;
    req_ch.value    <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_empty_readout();
    test_extreme_values();
    test_eviction_and_trim();
    test_clear_and_unused();
    test_keep_clamping();
    test_backpressure();
    test_random_phases();

    wait_drained();
    repeat (16) @(posedge clk);
    if (fail_count == 0) begin
      $display("top_n_distinct_value_counter_core test passed");
    end else begin
      $display("top_n_distinct_value_counter_core test failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/tndc_pkg.sv
hw/rtl/tndc_req_if.sv
hw/rtl/tndc_res_if.sv
hw/rtl/tndc_cell.sv
hw/rtl/tndc_readout.sv
hw/rtl/top_n_distinct_value_counter_core.sv
tb/tb_top.sv
